### rtl/srs_pkg.sv
// Package for the sparse row element store: sizes, opcodes, status codes,
// the transfer structs and the layout of one stored row. No dependencies.

package srs_pkg;

    localparam int MAX_ROWS      = 64;
    localparam int MAX_COLS      = 64;
    localparam int SLOTS_PER_ROW = 16;
    localparam int VALUE_WIDTH   = 32;

    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int CNT_W     = 7;
    localparam int SLOT_W    = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(64);

    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_SET   = 2'd1,
        OP_ACC   = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BOUNDS = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_opcode                        opcode;
        logic [ROW_W-1:0]               row_index;
        logic [COL_W-1:0]               col_index;
        logic signed [VALUE_WIDTH-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]  read_value;
        logic                           found;
        t_status                        status;
    } t_out_item;

    typedef struct packed {
        logic [SLOTS_PER_ROW-1:0]                  valid;
        logic [SLOTS_PER_ROW-1:0][COL_W-1:0]       column;
        logic [SLOTS_PER_ROW-1:0][VALUE_WIDTH-1:0] value;
    } t_row_word;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

### rtl/srs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module srs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/srs_datapath.sv
// Datapath of the sparse row element store: configuration registers, row
// memory, per-row initialized flags, slot search, update and result register.
// Depends on srs_pkg and srs_ram.

module srs_datapath
    import srs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_in_item              i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output t_out_item             o_out
);

    t_in_item              r_item;
    t_out_item             r_out;
    t_out_item             n_out;
    logic [CNT_W-1:0]      r_row_count;
    logic [CNT_W-1:0]      r_col_count;
    logic [MAX_ROWS-1:0]   r_row_init;

    logic [$bits(t_row_word)-1:0] rd_bits;
    t_row_word             rd_word;
    t_row_word             wr_word;
    logic                  mem_we;
    logic                  bad;
    logic                  row_live;
    logic [SLOTS_PER_ROW-1:0] live_mask;
    logic                  has_hit;
    logic                  has_free;
    logic [SLOT_W-1:0]     hit_idx;
    logic [SLOT_W-1:0]     free_idx;
    logic signed [VALUE_WIDTH-1:0] hit_val;
    logic signed [VALUE_WIDTH:0]   sum;
    logic signed [VALUE_WIDTH-1:0] new_val;
    logic                  sat;

    srs_ram #(
        .WIDTH ($bits(t_row_word)),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_item.row_index),
        .i_wdata (wr_word),
        .i_re    (i_cmd.capture),
        .i_raddr (i_in.row_index),
        .o_rdata (rd_bits)
    );

    assign rd_word   = t_row_word'(rd_bits);
    assign row_live  = r_row_init[r_item.row_index];
    assign live_mask = row_live ? rd_word.valid : '0;

    always_comb begin
        bad = (CNT_W'(r_item.row_index) >= r_row_count)
           || (CNT_W'(r_item.row_index) >= CNT_W'(MAX_ROWS));
        if (r_item.opcode != OP_CLEAR) begin
            if ((CNT_W'(r_item.col_index) >= r_col_count)
                || (CNT_W'(r_item.col_index) >= CNT_W'(MAX_COLS))) begin
                bad = 1'b1;
            end
        end
    end

    always_comb begin
        has_hit  = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = 0; s < SLOTS_PER_ROW; s++) begin
            if (live_mask[s]) begin
                if (!has_hit && rd_word.column[s] == r_item.col_index) begin
                    has_hit = 1'b1;
                    hit_idx = SLOT_W'(s);
                end
            end else if (!has_free) begin
                has_free = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    assign hit_val = has_hit ? rd_word.value[hit_idx] : '0;
    assign sum     = {hit_val[VALUE_WIDTH-1], hit_val}
                   + {r_item.value[VALUE_WIDTH-1], r_item.value};

    always_comb begin
        sat     = 1'b0;
        new_val = r_item.value;
        if (r_item.opcode == OP_ACC) begin
            if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) begin
                sat     = 1'b1;
                new_val = sum[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
            end else begin
                new_val = sum[VALUE_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        wr_word       = rd_word;
        wr_word.valid = live_mask;
        mem_we        = 1'b0;
        n_out         = '{read_value: '0, found: 1'b0, status: ST_OK};
        if (bad) begin
            n_out.status = ST_BOUNDS;
        end else begin
            case (r_item.opcode)
                OP_GET: begin
                    n_out.found      = has_hit;
                    n_out.read_value = hit_val;
                end
                OP_SET, OP_ACC: begin
                    mem_we      = i_cmd.execute;
                    n_out.found = has_hit;
                    if (sat) begin
                        n_out.status = ST_SAT;
                    end
                    if (has_hit) begin
                        n_out.read_value = new_val;
                        if (new_val != '0) begin
                            wr_word.value[hit_idx] = new_val;
                        end else begin
                            wr_word.valid[hit_idx] = 1'b0;
                        end
                    end else if (new_val != '0) begin
                        if (has_free) begin
                            wr_word.valid[free_idx]  = 1'b1;
                            wr_word.column[free_idx] = r_item.col_index;
                            wr_word.value[free_idx]  = new_val;
                            n_out.read_value         = new_val;
                        end else begin
                            n_out.status = ST_FULL;
                        end
                    end
                end
                default: begin
                    n_out.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= COUNT_RESET;
            r_col_count <= COUNT_RESET;
            r_row_init  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROW_COUNT: r_row_count <= i_cfg_data;
                    REG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.execute && !bad && r_item.opcode == OP_CLEAR) begin
                r_row_init[r_item.row_index] <= 1'b0;
            end else if (mem_we) begin
                r_row_init[r_item.row_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

### rtl/srs_ctrl.sv
// Controller of the sparse row element store: item sequencing and the
// handshakes of both channels. Depends on srs_pkg.

module srs_ctrl
    import srs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        in_ready      = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_out_valid   = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

### rtl/sparse_row_element_store.sv
// Top level of the sparse row element store: a sparse matrix kept as per-row
// slot lists with get, set, accumulate and clear row. Depends on srs_pkg,
// srs_ctrl and srs_datapath.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_ready   i_in  (t_in_item)
//   out       output     o_out_valid / i_out_ready o_out (t_out_item)
//   cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// Each item first has its row word read from the row memory; then the slots
// are searched, the word is updated and written back and the result is
// registered. A new transfer is taken in the cycle after the result is
// registered if the output is empty or drained in that cycle.
// Reset clears the counts to 64 and marks every row empty.
// A stalled output holds its result and blocks further input transfers.

module sparse_row_element_store
    import srs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd cmd;

    srs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    srs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input transfer taken while an item is in progress.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("No result two cycles after an input transfer.");

    a_bounds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_BOUNDS) |-> (!o_out.found && o_out.read_value == '0))
        else $error("Out of bounds result carries data.");

endmodule

### dv/sparse_row_element_store_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_row_element_store: directed and random
// get, set, accumulate and clear row traffic under several row and column
// counts, with a scoreboard class. Depends on srs_pkg and the top level RTL.

module sparse_row_element_store_tb
    import srs_pkg::*;
();

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_CYCLES = 150;

    class element_store_scoreboard;
        bit                      slot_used [MAX_ROWS][SLOTS_PER_ROW];
        logic [COL_W-1:0]        slot_col  [MAX_ROWS][SLOTS_PER_ROW];
        logic signed [31:0]      slot_val  [MAX_ROWS][SLOTS_PER_ROW];
        logic [CNT_W-1:0]        rows_in_use;
        logic [CNT_W-1:0]        cols_in_use;
        t_out_item               expected_results[$];
        int                      errors;

        function new();
            rows_in_use = COUNT_RESET;
            cols_in_use = COUNT_RESET;
            errors = 0;
            foreach (slot_used[r, s]) slot_used[r][s] = 1'b0;
        endfunction

        function void predict_transfer(t_in_item it);
            t_out_item res;
            int        hit;
            int        free_slot;
            int        row;
            longint    nv;
            longint    base;
            bit        oob;
            row = int'(it.row_index);
            hit = -1;
            free_slot = -1;
            res.read_value = '0;
            res.found = 1'b0;
            res.status = ST_OK;
            oob = (it.row_index >= rows_in_use)
                || (it.opcode != OP_CLEAR && it.col_index >= cols_in_use);
            if (oob) begin
                res.status = ST_BOUNDS;
            end else if (it.opcode == OP_CLEAR) begin
                for (int s = 0; s < SLOTS_PER_ROW; s++) slot_used[row][s] = 1'b0;
            end else begin
                for (int s = 0; s < SLOTS_PER_ROW; s++) begin
                    if (slot_used[row][s]) begin
                        if (hit < 0 && slot_col[row][s] == it.col_index) hit = s;
                    end else if (free_slot < 0) begin
                        free_slot = s;
                    end
                end
                res.found = (hit >= 0);
                if (it.opcode == OP_GET) begin
                    if (hit >= 0) res.read_value = slot_val[row][hit];
                end else begin
                    base = (it.opcode == OP_ACC && hit >= 0)
                        ? longint'(slot_val[row][hit]) : 64'sd0;
                    nv = base + longint'($signed(it.value));
                    if (nv > longint'(VALUE_MAX)) begin
                        nv = longint'(VALUE_MAX);
                        res.status = ST_SAT;
                    end else if (nv < longint'(VALUE_MIN)) begin
                        nv = longint'(VALUE_MIN);
                        res.status = ST_SAT;
                    end
                    if (hit >= 0) begin
                        if (nv != 0) slot_val[row][hit] = nv[31:0];
                        else slot_used[row][hit] = 1'b0;
                        res.read_value = nv[31:0];
                    end else if (nv != 0) begin
                        if (free_slot >= 0) begin
                            slot_used[row][free_slot] = 1'b1;
                            slot_col[row][free_slot] = it.col_index;
                            slot_val[row][free_slot] = nv[31:0];
                            res.read_value = nv[31:0];
                        end else begin
                            res.status = ST_FULL;
                        end
                    end
                end
            end
            expected_results = {expected_results, res};
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_res;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: value %h found %0d status %0d",
                         $time, got.read_value, got.found, got.status);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (got.read_value !== exp_res.read_value) begin
                $display("%0t: read_value expected %h actual %h",
                         $time, exp_res.read_value, got.read_value);
                errors++;
            end
            if (got.found !== exp_res.found) begin
                $display("%0t: found expected %0d actual %0d",
                         $time, exp_res.found, got.found);
                errors++;
            end
            if (got.status !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_res.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    element_store_scoreboard sb;
    int cycle_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    int ready_mode = 0;
    int mode_count = 0;
    int burst_left = 0;

    sparse_row_element_store DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out);
            results_seen = results_seen + 1;
            if (results_seen == 120 || results_seen == 330) hold_left = HOLD_CYCLES;
        end
        mode_count = mode_count + 1;
        if (mode_count % 64 == 0) ready_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= (mode_count % 3 == 0);
                default: i_out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    function automatic t_in_item make_op(t_opcode op, int row, int col, logic [31:0] v);
        t_in_item it;
        it.opcode = op;
        it.row_index = row[ROW_W-1:0];
        it.col_index = col[COL_W-1:0];
        it.value = v;
        return it;
    endfunction

    function automatic t_in_item random_op();
        t_in_item it;
        int pick;
        int row_lim;
        int col_lim;
        int small_val;
        row_lim = (sb.rows_in_use > MAX_ROWS) ? MAX_ROWS : sb.rows_in_use;
        col_lim = (sb.cols_in_use > MAX_COLS) ? MAX_COLS : sb.cols_in_use;
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
            it.opcode = t_opcode'($urandom_range(0, 3));
            it.row_index = ROW_W'($urandom);
            it.col_index = COL_W'($urandom);
            it.value = $urandom;
            return it;
        end
        if (pick < 30) it.opcode = OP_SET;
        else if (pick < 55) it.opcode = OP_ACC;
        else if (pick < 88) it.opcode = OP_GET;
        else it.opcode = OP_CLEAR;
        if (row_lim == 0) it.row_index = ROW_W'($urandom);
        else if ($urandom_range(0, 3) != 0)
            it.row_index = ROW_W'($urandom_range(0, ((row_lim < 4) ? row_lim : 4) - 1));
        else it.row_index = ROW_W'($urandom_range(0, row_lim - 1));
        if (col_lim == 0) it.col_index = COL_W'($urandom);
        else if ($urandom_range(0, 1) != 0)
            it.col_index = COL_W'($urandom_range(0, ((col_lim < 24) ? col_lim : 24) - 1));
        else it.col_index = COL_W'($urandom_range(0, col_lim - 1));
        small_val = $urandom_range(0, 16);
        small_val = small_val - 8;
        case ($urandom_range(0, 9))
            0: it.value = '0;
            1: it.value = VALUE_MAX;
            2: it.value = VALUE_MIN;
            3, 4, 5: it.value = small_val * 65536;
            default: it.value = $urandom;
        endcase
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.predict_transfer(it);
    endtask

    task automatic offer_item(t_in_item it);
        int gap;
        send_item(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_counts(int rows, int cols);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_ROW_COUNT;
        i_cfg_data <= rows[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= REG_COL_COUNT;
        i_cfg_data <= cols[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.rows_in_use = rows[CNT_W-1:0];
        sb.cols_in_use = cols[CNT_W-1:0];
    endtask

    initial begin
        int phase_rows [PHASES] = '{64, 20, 1, 127, 64, 2};
        int phase_cols [PHASES] = '{64, 33, 64, 127, 1, 64};
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_item(make_op(OP_SET, 0, 0, VALUE_MAX));
        offer_item(make_op(OP_ACC, 0, 0, 1));
        offer_item(make_op(OP_ACC, 0, 0, VALUE_MIN));
        offer_item(make_op(OP_ACC, 0, 0, 1));
        offer_item(make_op(OP_GET, 0, 0, 0));
        offer_item(make_op(OP_SET, 63, 63, VALUE_MIN));
        offer_item(make_op(OP_ACC, 63, 63, -1));
        offer_item(make_op(OP_CLEAR, 63, 63, $urandom));
        offer_item(make_op(OP_SET, 5, 7, 0));
        for (int c = 0; c <= SLOTS_PER_ROW; c++)
            offer_item(make_op(OP_SET, 9, c * 3, (c + 1) * 65536));
        wait_drained();
        set_counts(0, 0);
        offer_item(make_op(OP_GET, 0, 0, 0));
        wait_drained();
        set_counts(10, 10);
        offer_item(make_op(OP_SET, 10, 0, 1));
        offer_item(make_op(OP_SET, 0, 10, 1));

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            set_counts(phase_rows[p], phase_cols[p]);
            repeat (ITEMS_PER_PHASE) offer_item(random_op());
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
